FILE: hdl/fcbe_pkg.sv
// Shared constants and types for the front-compressed bigram extractor.
`default_nettype none

package fcbe_pkg;

  // Bytes in one line store; a chunk holds at most LINE_BYTES-1 bytes.
  localparam int LINE_BYTES = 1024;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int LEN_W      = ADDR_W + 1;

  localparam int BYTE_W     = 8;
  localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

  // Result queue between the compare stage and the output port.
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] first_byte;
  } pair_t;

endpackage

`default_nettype wire

FILE: hdl/fcbe_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fcbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fcbe_out_fifo.sv
// Small result queue that decouples the compare stage from the output handshake.
`default_nettype none

module fcbe_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire fcbe_pkg::pair_t               push_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fcbe_pkg::pair_t                    out_data,
  output logic [fcbe_pkg::FIFO_CNT_W-1:0]    level
);

  fcbe_pkg::pair_t                     slots [fcbe_pkg::FIFO_DEPTH];
  logic [fcbe_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [fcbe_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic                                pop;

  function automatic logic [fcbe_pkg::FIFO_PTR_W-1:0] bump(
    input logic [fcbe_pkg::FIFO_PTR_W-1:0] ptr
  );
    if (ptr == fcbe_pkg::FIFO_PTR_W'(fcbe_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign out_valid = (level != '0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/front_compressed_bigram_extractor_core.sv
// A bigram is formed in the compare stage and written into the result queue, which drives m_tvalid.
// Throughput: one item per cycle while s_tready is high; each item does one read of the
// previous-line store, and each nonzero byte does one write of the current-line store.
// The input stalls only when the three-entry result queue could overflow.
// Reset is synchronous; no clearing pass runs: entry 0 of store a reads as a space
// through a flag until it is first written.
`default_nettype none

module front_compressed_bigram_extractor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tlast,   // line_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [7:0] first_byte, [15:8] second_byte
);

  localparam logic [fcbe_pkg::ADDR_W-1:0] LAST_POS =
    fcbe_pkg::ADDR_W'(fcbe_pkg::LINE_BYTES - 1);

  // Front stage: addressing state.
  logic                          current_is_b;
  logic [fcbe_pkg::ADDR_W-1:0]   position;
  logic [fcbe_pkg::LEN_W-1:0]    length_a;
  logic [fcbe_pkg::LEN_W-1:0]    length_b;
  logic                          a0_written;

  logic                          accept;
  logic                          byte_ok;
  logic [fcbe_pkg::ADDR_W-1:0]   pos_inc;
  logic [fcbe_pkg::LEN_W-1:0]    prev_len;
  logic                          line_end;

  // Compare stage.
  logic                          s2_valid;
  logic                          s2_byte_ok;
  logic                          s2_end;
  logic                          s2_in_range;
  logic                          s2_cur_b;
  logic                          s2_a0_dflt;
  logic [fcbe_pkg::BYTE_W-1:0]   s2_ch;
  logic                          still_in_prefix;
  logic                          held_valid;
  logic [fcbe_pkg::BYTE_W-1:0]   held_byte;

  logic [fcbe_pkg::BYTE_W-1:0]   a_rdata;
  logic [fcbe_pkg::BYTE_W-1:0]   b_rdata;
  logic [fcbe_pkg::BYTE_W-1:0]   prev_byte;
  logic                          skip;
  logic                          emit;
  fcbe_pkg::pair_t               pair;
  fcbe_pkg::pair_t               out_pair;
  logic [fcbe_pkg::FIFO_CNT_W-1:0] level;

  assign accept   = s_tvalid && s_tready;
  assign byte_ok  = (s_tdata != fcbe_pkg::NUL_BYTE);
  assign pos_inc  = position + 1'b1;
  assign prev_len = current_is_b ? length_a : length_b;
  assign line_end = s_tlast || (byte_ok && (pos_inc == LAST_POS));

  // Room is kept for every item that may still be in flight toward the queue.
  assign s_tready = (32'(level) + 32'(s2_valid)) < fcbe_pkg::FIFO_DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_is_b <= 1'b1;
      position     <= '0;
      length_a     <= fcbe_pkg::LEN_W'(1);
      length_b     <= '0;
      a0_written   <= 1'b0;
    end else if (accept) begin
      if (byte_ok && !current_is_b && (position == '0)) begin
        a0_written <= 1'b1;
      end
      if (line_end) begin
        if (current_is_b) begin
          length_b <= byte_ok ? {1'b0, pos_inc} : {1'b0, position};
        end else begin
          length_a <= byte_ok ? {1'b0, pos_inc} : {1'b0, position};
        end
        current_is_b <= !current_is_b;
        position     <= '0;
      end else if (byte_ok) begin
        position <= pos_inc;
      end
    end
  end

  fcbe_ram #(
    .WIDTH (fcbe_pkg::BYTE_W),
    .DEPTH (fcbe_pkg::LINE_BYTES)
  ) u_store_a (
    .clk   (clk),
    .we    (accept && byte_ok && !current_is_b),
    .waddr (position),
    .wdata (s_tdata),
    .re    (accept && current_is_b),
    .raddr (position),
    .rdata (a_rdata)
  );

  fcbe_ram #(
    .WIDTH (fcbe_pkg::BYTE_W),
    .DEPTH (fcbe_pkg::LINE_BYTES)
  ) u_store_b (
    .clk   (clk),
    .we    (accept && byte_ok && current_is_b),
    .waddr (position),
    .wdata (s_tdata),
    .re    (accept && !current_is_b),
    .raddr (position),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_byte_ok  <= byte_ok;
      s2_end      <= line_end;
      s2_in_range <= ({1'b0, position} < prev_len);
      s2_cur_b    <= current_is_b;
      s2_a0_dflt  <= current_is_b && (position == '0) && !a0_written;
      s2_ch       <= s_tdata;
    end
  end

  assign prev_byte = s2_a0_dflt ? fcbe_pkg::SPACE_BYTE : (s2_cur_b ? a_rdata : b_rdata);
  assign skip      = still_in_prefix && s2_in_range && (prev_byte == s2_ch);
  assign emit      = s2_valid && s2_byte_ok && !skip && held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      still_in_prefix <= 1'b1;
      held_valid      <= 1'b0;
    end else if (s2_valid) begin
      if (s2_end) begin
        still_in_prefix <= 1'b1;
        held_valid      <= 1'b0;
      end else if (s2_byte_ok && !skip) begin
        still_in_prefix <= 1'b0;
        held_valid      <= !held_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_byte_ok && !skip && !held_valid) begin
      held_byte <= s2_ch;
    end
  end

  assign pair.first_byte  = held_byte;
  assign pair.second_byte = s2_ch;

  fcbe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (pair),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_pair),
    .level     (level)
  );

  assign m_tdata = {out_pair.second_byte, out_pair.first_byte};

endmodule

`default_nettype wire

FILE: hdl/fcbe_checker.sv
// Port-level checks for the bigram extractor, bound to the top level.
`default_nettype none

module fcbe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its bytes.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // Zero bytes are never stored, so neither byte of a pair can be zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] != 8'h00) && (m_tdata[15:8] != 8'h00))
    else $error("bigram holds a zero byte");

  // A result out of an empty queue was completed by an accepted item that passed the compare stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a completing item");

endmodule

bind front_compressed_bigram_extractor_core fcbe_checker u_fcbe_checker (.*);

`default_nettype wire

FILE: bench/front_compressed_bigram_extractor_core_test.sv
// Self-checking bench for the front-compressed bigram extractor core.
`timescale 1ns / 100ps

module front_compressed_bigram_extractor_core_test;

  typedef struct {
    logic [fcbe_pkg::BYTE_W-1:0] ch;
    logic                        last;
    bit                          drain;
  } path_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] ch
  logic        s_tlast = 1'b0; // line_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] first_byte, [15:8] second_byte

  front_compressed_bigram_extractor_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  path_item_t       bytes_to_send[$];
  fcbe_pkg::pair_t  bigrams_due[$];
  bit               drain_next = 1'b0;
  int               err_count = 0;

  // Shadow copy of the two line stores and the pairing state.
  logic [fcbe_pkg::BYTE_W-1:0] store_a [fcbe_pkg::LINE_BYTES];
  logic [fcbe_pkg::BYTE_W-1:0] store_b [fcbe_pkg::LINE_BYTES];
  int unsigned                 len_a, len_b, pos;
  bit                          cur_is_b, in_prefix, held_ok;
  logic [fcbe_pkg::BYTE_W-1:0] held;

  bit in_took = 1'b0, out_took = 1'b0;
  bit tx_calm = 1'b0, rx_calm = 1'b0;
  int gap_left = 0, rx_wait = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic queue_byte(input logic [fcbe_pkg::BYTE_W-1:0] c, input logic l);
    path_item_t it;
    it.ch = c;
    it.last = l;
    it.drain = drain_next;
    drain_next = 1'b0;
    bytes_to_send.push_back(it);
  endtask

  task automatic absorb_byte(input logic [fcbe_pkg::BYTE_W-1:0] ch, input logic last_in);
    logic                        ends;
    int unsigned                 p, prev_len;
    logic [fcbe_pkg::BYTE_W-1:0] prev_b;
    fcbe_pkg::pair_t             pr;
    ends = last_in;
    prev_len = cur_is_b ? len_a : len_b;
    if (ch != fcbe_pkg::NUL_BYTE && pos < fcbe_pkg::LINE_BYTES) begin
      p = pos;
      prev_b = cur_is_b ? store_a[p] : store_b[p];
      if (cur_is_b) store_b[p] = ch;
      else store_a[p] = ch;
      if (!(in_prefix && p < prev_len && prev_b == ch)) begin
        in_prefix = 1'b0;
        if (held_ok) begin
          pr.first_byte = held;
          pr.second_byte = ch;
          bigrams_due.push_back(pr);
          held_ok = 1'b0;
        end else begin
          held = ch;
          held_ok = 1'b1;
        end
      end
      pos = p + 1;
      // A chunk that fills the store ends as if the line had ended.
      if (pos >= fcbe_pkg::LINE_BYTES - 1) ends = 1'b1;
    end
    if (ends) begin
      if (cur_is_b) len_b = pos;
      else len_a = pos;
      cur_is_b = !cur_is_b;
      pos = 0;
      in_prefix = 1'b1;
      held_ok = 1'b0;
    end
  endtask

  initial begin : stimulus_proc
    logic [fcbe_pkg::BYTE_W-1:0] prev_line[$];
    logic [fcbe_pkg::BYTE_W-1:0] this_line[$];
    int unsigned                 sent, keep, body, k;
    bit                          narrow, zero_end, long_done;
    long_done = 1'b0;

    // The first line starts with the space that the reset line holds.
    queue_byte(fcbe_pkg::SPACE_BYTE, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h0A, 1'b1);
    // Same prefix, an ignored zero byte inside, then a mismatch.
    queue_byte(fcbe_pkg::SPACE_BYTE, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(fcbe_pkg::NUL_BYTE, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h0A, 1'b1);
    // An empty line, then a line with nothing to compare against.
    queue_byte(fcbe_pkg::NUL_BYTE, 1'b1);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h79, 1'b1);
    // Single-byte lines, the repeat of one is fully skipped.
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h01, 1'b1);
    // Longer than the previous line, then a line ended by a zero byte.
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(fcbe_pkg::NUL_BYTE, 1'b1);
    drain_next = 1'b1;

    sent = 0;
    while (sent < 1350) begin
      this_line.delete();
      zero_end = 1'b0;
      if (!long_done && sent > 200) begin
        repeat (fcbe_pkg::LINE_BYTES - 1 + $urandom_range(1, 20))
          this_line.push_back(8'($urandom_range(1, 255)));
        long_done = 1'b1;
      end else begin
        narrow = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) begin
          keep = $urandom_range(0, prev_line.size() < 30 ? prev_line.size() : 30);
          for (k = 0; k < keep; k++) this_line.push_back(prev_line[k]);
        end
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (body)
          this_line.push_back(narrow ?
            (($urandom_range(0, 3) == 0) ? 8'h2F : 8'(8'h61 + $urandom_range(0, 2))) :
            8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) < 7) this_line.push_back(8'h0A);
        zero_end = ($urandom_range(0, 19) == 0);
      end
      if ($urandom_range(0, 149) == 0) drain_next = 1'b1;
      if (this_line.size() == 0) begin
        queue_byte(fcbe_pkg::NUL_BYTE, 1'b1);
      end else begin
        for (k = 0; k < this_line.size(); k++) begin
          if ($urandom_range(0, 39) == 0) queue_byte(fcbe_pkg::NUL_BYTE, 1'b0);
          queue_byte(this_line[k], !zero_end && k == this_line.size() - 1);
        end
        if (zero_end) queue_byte(fcbe_pkg::NUL_BYTE, 1'b1);
      end
      sent += this_line.size();
      // After a split line the block compares against the trailing chunk.
      if (this_line.size() > fcbe_pkg::LINE_BYTES - 1) begin
        prev_line.delete();
        for (k = fcbe_pkg::LINE_BYTES - 1; k < this_line.size(); k++)
          prev_line.push_back(this_line[k]);
      end else begin
        prev_line = this_line;
      end
    end
  end

  always @(negedge clk) begin : drive_proc
    logic       nv;
    path_item_t it;
    nv = s_tvalid;
    if (!rst && (!s_tvalid || in_took)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (bytes_to_send.size() != 0 &&
                   !(bytes_to_send[0].drain && bigrams_due.size() != 0)) begin
        it = bytes_to_send.pop_front();
        s_tdata <= it.ch;
        s_tlast <= it.last;
        nv = 1'b1;
        gap_left = draw_wait(tx_calm);
      end
    end
    s_tvalid <= nv;
  end

  always @(negedge clk) begin : accept_proc
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (out_took) rx_wait = draw_wait(rx_calm);
      if (rx_wait > 0) rx_wait--;
      else nr = 1'b1;
    end
    m_tready <= nr;
  end

  always @(posedge clk) begin : monitor_proc
    fcbe_pkg::pair_t got, want;
    if (rst) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      store_a[0] = fcbe_pkg::SPACE_BYTE;
      len_a = 1;
      len_b = 0;
      cur_is_b = 1'b1;
      pos = 0;
      in_prefix = 1'b1;
      held = '0;
      held_ok = 1'b0;
    end else begin
      in_took <= s_tvalid && s_tready;
      out_took <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (bigrams_due.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected bigram %h %h", got.first_byte, got.second_byte);
        end else begin
          want = bigrams_due.pop_front();
          if (got.first_byte !== want.first_byte || got.second_byte !== want.second_byte) begin
            err_count++;
            if (err_count <= 10)
              $display("bigram mismatch: first exp %h got %h, second exp %h got %h",
                       want.first_byte, got.first_byte, want.second_byte, got.second_byte);
          end
        end
      end
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
    end
  end

  initial begin : finish_proc
    wait (rst == 1'b0);
    while (bytes_to_send.size() != 0 || s_tvalid) @(posedge clk);
    while (bigrams_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("front_compressed_bigram_extractor_core verification clean");
    end else begin
      $display("front_compressed_bigram_extractor_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #4000000;
    $display("front_compressed_bigram_extractor_core verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/fcbe_pkg.sv
hdl/fcbe_ram.sv
hdl/fcbe_out_fifo.sv
hdl/front_compressed_bigram_extractor_core.sv
hdl/fcbe_checker.sv
bench/front_compressed_bigram_extractor_core_test.sv
